[sv/qrw_pkg.sv]
// Shared types, constants and address helper for the QR data-module walker.
// Used by qrw_map and qr_data_module_walker; depends on nothing else.
package qrw_pkg;

    localparam int MAX_SIDE  = 177;
    localparam int HALF_COLS = (MAX_SIDE + 1) / 2;
    localparam int MAP_DEPTH = MAX_SIDE * HALF_COLS;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_NEXT  = 2'd2;

    localparam logic [1:0] REG_SIDE   = 2'd0;
    localparam logic [1:0] REG_TIMING = 2'd1;

    typedef logic [MAP_AW-1:0] map_addr_t;

    typedef struct packed {
        logic      en;
        logic      bank;
        map_addr_t addr;
        logic      data;
    } map_wr_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PROBE = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_SCAN  = 4'b1000
    } state_t;

    // Row-major address into one column-parity bank.
    function automatic map_addr_t map_addr(input logic [7:0] row, input logic [6:0] half);
        map_addr_t prod;
        prod = map_addr_t'(row) * map_addr_t'(HALF_COLS) + map_addr_t'(half);
        return prod;
    endfunction

endpackage

[sv/qrw_map.sv]
// Module flag store: two one-bit banks split by column parity, so both columns of a
// pair are read together into registered outputs. Depends on qrw_pkg.
module qrw_map (
    input  logic              clk,
    input  qrw_pkg::map_wr_t  wr,
    input  qrw_pkg::map_addr_t rd_addr_e,
    input  qrw_pkg::map_addr_t rd_addr_o,
    output logic              rd_e,
    output logic              rd_o
);

    logic map_even [qrw_pkg::MAP_DEPTH];
    logic map_odd  [qrw_pkg::MAP_DEPTH];
    logic rd_e_reg;
    logic rd_o_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.bank)
        begin
            map_even[wr.addr] <= wr.data;
        end
        if (wr.en && wr.bank)
        begin
            map_odd[wr.addr] <= wr.data;
        end
        rd_e_reg <= map_even[rd_addr_e];
        rd_o_reg <= map_odd[rd_addr_o];
    end

    assign rd_e = rd_e_reg;
    assign rd_o = rd_o_reg;

endmodule

[sv/qr_data_module_walker.sv]
// QR data-module walker: loads, start and next-position requests; uses qrw_map.
// A load or start is taken in the idle state, which stays ready. A request whose
// result is held or is the end marker goes through the emit state to m_axis; a fresh
// request goes through the probe and emit states (emit waits for m_axis to be free),
// then the walk scans one row per cycle (map read port) to the next data row before the next input is taken.
// Reset sets the walk, control and config registers only; the flag map is undefined until loaded.
module qr_data_module_walker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // in_col[7:0], in_row[15:8], in_is_data[16]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_col[7:0], out_row[15:8]
    output logic        m_axis_tuser,   // found[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    qrw_pkg::state_t    state_reg, state_next;
    logic [7:0]         side_reg, timing_reg;
    logic signed [8:0]  col_reg, col_next;
    logic signed [8:0]  row_reg, row_next;
    logic               up_reg, up_next;
    logic               phase_reg, phase_next;
    logic               scan_after_reg, scan_after_next;
    logic               held_valid_reg, held_valid_next;
    logic [7:0]         held_col_reg, held_col_next;
    logic [7:0]         held_row_reg, held_row_next;
    logic               res_found_reg, res_found_next;
    logic [7:0]         res_col_reg, res_col_next;
    logic [7:0]         res_row_reg, res_row_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [7:0]         out_col_reg, out_col_next;
    logic [7:0]         out_row_reg, out_row_next;

    logic               in_acc;
    logic [1:0]         act;
    logic [7:0]         ld_col, ld_row;
    logic               ld_flag;
    logic [7:0]         side_eff;
    logic signed [8:0]  side_s;
    logic signed [8:0]  col_l, col_m2, col_sh, row_step;
    logic               col_ok_r, col_ok_l, row_ok;
    logic               dat_r, dat_l, pr, pl, pair, at_bound, out_free;
    logic               rd_e, rd_o;
    logic               a_ok;
    logic [6:0]         a_half, a_half_o;
    qrw_pkg::map_addr_t rd_addr_e, rd_addr_o;
    qrw_pkg::map_wr_t   wr;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign act     = s_axis_tuser;
    assign ld_col  = s_axis_tdata[7:0];
    assign ld_row  = s_axis_tdata[15:8];
    assign ld_flag = s_axis_tdata[16];

    assign s_axis_tready = (state_reg == qrw_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_row_reg, out_col_reg};
    assign m_axis_tuser  = out_found_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign side_eff = (side_reg > 8'(qrw_pkg::MAX_SIDE)) ? 8'(qrw_pkg::MAX_SIDE) : side_reg;
    assign side_s   = $signed({1'b0, side_eff});

    // Probe of the pair at the current position; read data belongs to col_reg/row_reg.
    assign col_l    = col_reg - 9'sd1;
    assign col_ok_r = (col_reg >= 9'sd0) && (col_reg < side_s);
    assign col_ok_l = (col_l >= 9'sd0) && (col_l < side_s);
    assign row_ok   = (row_reg >= 9'sd0) && (row_reg < side_s);
    assign dat_r    = col_reg[0] ? rd_o : rd_e;
    assign dat_l    = col_reg[0] ? rd_e : rd_o;
    assign pr       = col_ok_r && row_ok && dat_r;
    assign pl       = col_ok_l && row_ok && dat_l;
    assign pair     = pr || pl;
    assign at_bound = up_reg ? (row_reg < 9'sd0) : (row_reg >= side_s);
    assign row_step = up_reg ? (row_reg - 9'sd1) : (row_reg + 9'sd1);
    assign col_m2   = col_reg - 9'sd2;
    assign col_sh   = (!col_m2[8] && (col_m2[7:0] == timing_reg)) ? (col_m2 - 9'sd1) : col_m2;

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        up_next         = up_reg;
        phase_next      = phase_reg;
        scan_after_next = scan_after_reg;
        held_valid_next = held_valid_reg;
        held_col_next   = held_col_reg;
        held_row_next   = held_row_reg;
        res_found_next  = res_found_reg;
        res_col_next    = res_col_reg;
        res_row_next    = res_row_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_found_next  = out_found_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;

        unique case (state_reg)
            qrw_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (act)
                        qrw_pkg::ACT_START:
                        begin
                            col_next        = side_s - 9'sd1;
                            row_next        = side_s - 9'sd1;
                            up_next         = 1'b1;
                            held_valid_next = 1'b0;
                            held_col_next   = 8'd0;
                            held_row_next   = 8'd0;
                        end
                        qrw_pkg::ACT_NEXT:
                        begin
                            priority if (held_valid_reg)
                            begin
                                held_valid_next = 1'b0;
                                res_found_next  = 1'b1;
                                res_col_next    = held_col_reg;
                                res_row_next    = held_row_reg;
                                scan_after_next = 1'b0;
                                state_next      = qrw_pkg::ST_EMIT;
                            end
                            else if ((col_reg < 9'sd0) || (row_reg < 9'sd0))
                            begin
                                res_found_next  = 1'b0;
                                res_col_next    = 8'd0;
                                res_row_next    = 8'd0;
                                scan_after_next = 1'b0;
                                state_next      = qrw_pkg::ST_EMIT;
                            end
                            else
                            begin
                                state_next = qrw_pkg::ST_PROBE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            qrw_pkg::ST_PROBE:
            begin
                res_found_next = 1'b1;
                res_row_next   = row_reg[7:0];
                if (pr)
                begin
                    res_col_next = col_reg[7:0];
                    if (pl)
                    begin
                        held_valid_next = 1'b1;
                        held_col_next   = col_l[7:0];
                        held_row_next   = row_reg[7:0];
                    end
                end
                else
                begin
                    res_col_next = col_l[7:0];
                end
                row_next        = row_step;
                phase_next      = 1'b0;
                scan_after_next = 1'b1;
                state_next      = qrw_pkg::ST_EMIT;
            end
            qrw_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_col_next   = res_col_reg;
                    out_row_next   = res_row_reg;
                    state_next     = scan_after_reg ? qrw_pkg::ST_SCAN : qrw_pkg::ST_IDLE;
                end
            end
            qrw_pkg::ST_SCAN:
            begin
                // Off the edge: turn once and scan the new pair from the same edge.
                priority if (at_bound)
                begin
                    if (!phase_reg)
                    begin
                        up_next  = !up_reg;
                        col_next = col_sh;
                        if (col_sh >= 9'sd0)
                        begin
                            row_next   = up_reg ? 9'sd0 : (side_s - 9'sd1);
                            phase_next = 1'b1;
                        end
                        else
                        begin
                            state_next = qrw_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = qrw_pkg::ST_IDLE;
                    end
                end
                else if (pair)
                begin
                    state_next = qrw_pkg::ST_IDLE;
                end
                else
                begin
                    row_next = row_step;
                end
            end
            default:
            begin
                state_next = qrw_pkg::ST_IDLE;
            end
        endcase
    end

    // Read the pair at the next position so its flags arrive with the registers.
    assign a_ok     = (row_next >= 9'sd0) && (row_next < 9'(qrw_pkg::MAX_SIDE))
                   && (col_next >= 9'sd0) && (col_next < 9'(qrw_pkg::MAX_SIDE));
    assign a_half   = a_ok ? col_next[7:1] : 7'd0;
    assign a_half_o = (col_next[0] || (a_half == 7'd0)) ? a_half : (a_half - 7'd1);
    assign rd_addr_e = qrw_pkg::map_addr(a_ok ? row_next[7:0] : 8'd0, a_half);
    assign rd_addr_o = qrw_pkg::map_addr(a_ok ? row_next[7:0] : 8'd0, a_half_o);

    assign wr.en   = in_acc && (act == qrw_pkg::ACT_LOAD)
                  && (ld_col < 8'(qrw_pkg::MAX_SIDE)) && (ld_row < 8'(qrw_pkg::MAX_SIDE));
    assign wr.bank = ld_col[0];
    assign wr.addr = qrw_pkg::map_addr(ld_row, ld_col[7:1]);
    assign wr.data = ld_flag;

    qrw_map u_map (
        .clk       (clk),
        .wr        (wr),
        .rd_addr_e (rd_addr_e),
        .rd_addr_o (rd_addr_o),
        .rd_e      (rd_e),
        .rd_o      (rd_o)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= qrw_pkg::ST_IDLE;
            side_reg       <= 8'd21;
            timing_reg     <= 8'd6;
            col_reg        <= 9'sd20;
            row_reg        <= 9'sd20;
            up_reg         <= 1'b1;
            phase_reg      <= 1'b0;
            scan_after_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            held_col_reg   <= 8'd0;
            held_row_reg   <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            up_reg         <= up_next;
            phase_reg      <= phase_next;
            scan_after_reg <= scan_after_next;
            held_valid_reg <= held_valid_next;
            held_col_reg   <= held_col_next;
            held_row_reg   <= held_row_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    qrw_pkg::REG_SIDE:   side_reg   <= cfg_data;
                    qrw_pkg::REG_TIMING: timing_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_found_reg <= res_found_next;
        res_col_reg   <= res_col_next;
        res_row_reg   <= res_row_next;
        out_found_reg <= out_found_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
    end

    // A held left member always sits one column left of the right member just found.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(held_valid_reg) |-> (res_col_reg == held_col_reg + 8'd1)
                                  && (res_row_reg == held_row_reg))
        else $error("held position does not pair with emitted position");

    // The row scan stays within rows -1 to 178 while scanning.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qrw_pkg::ST_SCAN) |-> (row_reg >= -9'sd1) && (row_reg < 9'sd179))
        else $error("scan row out of range");

    // Direction changes only at an edge turn or on a start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (up_reg != $past(up_reg)) |-> ($past(state_reg) == qrw_pkg::ST_SCAN)
                                      || $past(in_acc && (act == qrw_pkg::ACT_START)))
        else $error("walk direction changed outside a turn or start");

endmodule
